// ===== design/kbt_pkg.sv =====
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types, constants and helpers for the keyed block transposition.
// ----------------------------------------------------------------------------
package kbt_pkg;

  localparam int KEY_MAX  = 8;
  localparam int IDX_W    = $clog2(KEY_MAX);
  localparam int LEN_W    = 4;
  localparam int BANKS    = 2;
  localparam int BANK_W   = $clog2(BANKS);
  localparam int RAM_AW   = BANK_W + IDX_W;
  localparam int RAM_DEPTH = BANKS * KEY_MAX;
  localparam int Q_DEPTH  = BANKS;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W = 2;
  localparam int KEY_W    = 8 * KEY_MAX;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH  = 2'd0,
    CFG_KEY_BYTES   = 2'd1,
    CFG_DECODE_MODE = 2'd2
  } kbt_cfg_idx_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_RUN  = 1'b1
  } kbt_back_state_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [LEN_W-1:0]  count;
    logic              permute;
    logic              fin;
  } kbt_job_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } kbt_release_t;

  typedef logic [KEY_MAX-1:0][IDX_W-1:0] kbt_idx_vec_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] l;
    l = len;
    if (l == '0) l = LEN_W'(1);
    if (l > LEN_W'(KEY_MAX)) l = LEN_W'(KEY_MAX);
    return l;
  endfunction

endpackage

// ===== design/kbt_ram.sv =====
// ----------------------------------------------------------------------------
// kbt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/kbt_order.sv =====
// ----------------------------------------------------------------------------
// kbt_order
// Builds the stable ascending key order and its inverse as read-index tables.
// ----------------------------------------------------------------------------
module kbt_order (
  input  logic                    clk,
  input  logic [kbt_pkg::KEY_W-1:0] key_bytes,
  input  logic [kbt_pkg::LEN_W-1:0] len,
  output kbt_pkg::kbt_idx_vec_t   enc_src,
  output kbt_pkg::kbt_idx_vec_t   dec_src
);

  kbt_pkg::kbt_idx_vec_t rank_nxt;
  kbt_pkg::kbt_idx_vec_t rank_r;
  kbt_pkg::kbt_idx_vec_t enc_nxt;
  kbt_pkg::kbt_idx_vec_t enc_r;
  logic [kbt_pkg::LEN_W-1:0] len_r;

  always_comb begin
    logic [7:0] ki;
    logic [7:0] kj;
    logic [kbt_pkg::IDX_W-1:0] cnt;
    for (int i = 0; i < kbt_pkg::KEY_MAX; i++) begin
      ki = key_bytes[8*i +: 8];
      cnt = '0;
      for (int j = 0; j < kbt_pkg::KEY_MAX; j++) begin
        kj = key_bytes[8*j +: 8];
        if ((kbt_pkg::LEN_W'(j) < len) && (j != i) &&
            ((kj < ki) || ((kj == ki) && (j < i)))) begin
          cnt = cnt + kbt_pkg::IDX_W'(1);
        end
      end
      rank_nxt[i] = cnt;
    end
  end

  always_comb begin
    for (int k = 0; k < kbt_pkg::KEY_MAX; k++) begin
      enc_nxt[k] = '0;
      for (int i = 0; i < kbt_pkg::KEY_MAX; i++) begin
        if ((kbt_pkg::LEN_W'(i) < len_r) && (rank_r[i] == kbt_pkg::IDX_W'(k))) begin
          enc_nxt[k] = kbt_pkg::IDX_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    len_r  <= len;
    enc_r  <= enc_nxt;
  end

  assign enc_src = enc_r;
  assign dec_src = rank_r;

endmodule

// ===== design/kbt_front.sv =====
// ----------------------------------------------------------------------------
// kbt_front
// Accepts bytes into the open bank and queues a job when a block closes.
// ----------------------------------------------------------------------------
module kbt_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_byte,
  input  logic                       in_final,
  input  logic [kbt_pkg::LEN_W-1:0]  len,
  input  kbt_pkg::kbt_release_t      release_i,
  output logic                       we,
  output logic [kbt_pkg::RAM_AW-1:0] waddr,
  output logic [7:0]                 wdata,
  output logic                       job_push,
  output kbt_pkg::kbt_job_t          job
);

  logic [kbt_pkg::LEN_W-1:0]  fill_r, fill_nxt;
  logic [kbt_pkg::BANK_W-1:0] bank_r, bank_nxt;
  logic [kbt_pkg::BANKS-1:0]  busy_r, busy_nxt;
  logic [kbt_pkg::LEN_W-1:0]  slot;
  logic [kbt_pkg::LEN_W-1:0]  next_fill;
  logic                       accept;

  assign full   = busy_r[bank_r];
  assign accept = push && !full;
  assign slot   = (fill_r >= len) ? '0 : fill_r;
  assign next_fill = slot + kbt_pkg::LEN_W'(1);

  assign we    = accept;
  assign waddr = {bank_r, slot[kbt_pkg::IDX_W-1:0]};
  assign wdata = in_byte;

  always_comb begin
    fill_nxt = fill_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    job_push = 1'b0;
    job.bank    = bank_r;
    job.count   = next_fill;
    job.permute = (next_fill == len);
    job.fin     = in_final;
    if (release_i.valid) begin
      busy_nxt[release_i.bank] = 1'b0;
    end
    if (accept) begin
      if ((next_fill == len) || in_final) begin
        job_push = 1'b1;
        fill_nxt = '0;
        bank_nxt = bank_r + kbt_pkg::BANK_W'(1);
        busy_nxt[bank_r] = 1'b1;
      end else begin
        fill_nxt = next_fill;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bank_r <= '0;
      busy_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== design/kbt_queue.sv =====
// ----------------------------------------------------------------------------
// kbt_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module kbt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  kbt_pkg::kbt_job_t wr_job,
  input  logic              rd,
  output logic              empty,
  output kbt_pkg::kbt_job_t rd_job
);

  kbt_pkg::kbt_job_t slots [kbt_pkg::Q_DEPTH];
  logic [kbt_pkg::Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [kbt_pkg::Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [kbt_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty  = (cnt_r == '0);
  assign rd_job = slots[rptr_r];

  always_comb begin
    wptr_nxt = wr ? wptr_r + kbt_pkg::Q_PTR_W'(1) : wptr_r;
    rptr_nxt = rd ? rptr_r + kbt_pkg::Q_PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + kbt_pkg::Q_CNT_W'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - kbt_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== design/kbt_back.sv =====
// ----------------------------------------------------------------------------
// kbt_back
// Walks one queued block, reading a byte per beat, permuted if the block is full.
// ----------------------------------------------------------------------------
module kbt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  kbt_pkg::kbt_job_t          q_job,
  output logic                       q_pop,
  input  logic                       decode_mode,
  input  kbt_pkg::kbt_idx_vec_t      enc_src,
  input  kbt_pkg::kbt_idx_vec_t      dec_src,
  output logic                       re,
  output logic [kbt_pkg::RAM_AW-1:0] raddr,
  output kbt_pkg::kbt_release_t      release_o,
  input  logic                       pop,
  output logic                       empty,
  output logic                       out_run_last,
  output logic                       out_message_end
);

  kbt_pkg::kbt_back_state_t  state_r, state_nxt;
  kbt_pkg::kbt_job_t         job_r, job_nxt;
  logic [kbt_pkg::IDX_W-1:0] k_r, k_nxt;
  logic                      out_v_r, out_v_nxt;
  logic                      last_r, last_nxt;
  logic                      end_r, end_nxt;
  logic [kbt_pkg::IDX_W-1:0] src;
  logic                      last_beat;
  logic                      out_pop;

  assign out_pop   = pop && out_v_r;
  assign last_beat = ((kbt_pkg::LEN_W'(k_r) + kbt_pkg::LEN_W'(1)) == job_r.count);

  always_comb begin
    if (!job_r.permute) begin
      src = k_r;
    end else if (decode_mode) begin
      src = dec_src[k_r];
    end else begin
      src = enc_src[k_r];
    end
  end

  assign raddr = {job_r.bank, src};

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    end_nxt   = end_r;
    q_pop     = 1'b0;
    re        = 1'b0;
    release_o.valid = 1'b0;
    release_o.bank  = job_r.bank;
    out_v_nxt = out_pop ? 1'b0 : out_v_r;
    case (state_r)
      kbt_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          k_nxt     = '0;
          state_nxt = kbt_pkg::B_RUN;
        end
      end
      kbt_pkg::B_RUN: begin
        if (!out_v_r || out_pop) begin
          re        = 1'b1;
          out_v_nxt = 1'b1;
          last_nxt  = last_beat;
          end_nxt   = last_beat && job_r.fin;
          if (last_beat) begin
            release_o.valid = 1'b1;
            state_nxt = kbt_pkg::B_IDLE;
          end else begin
            k_nxt = k_r + kbt_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = kbt_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    k_r    <= k_nxt;
    last_r <= last_nxt;
    end_r  <= end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kbt_pkg::B_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign empty           = !out_v_r;
  assign out_run_last    = last_r;
  assign out_message_end = end_r;

endmodule

// ===== design/keyed_block_transposition.sv =====
// ----------------------------------------------------------------------------
// keyed_block_transposition
// Byte-stream block transposition keyed by the stable order of the key bytes.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------
//  input   | push / full        | in_byte, in_final
//  result  | pop / empty        | out_byte, out_run_last, out_message_end
//  config  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Bytes are taken one per cycle while full is low, into the open bank of a
//  two-bank block store; a closed block is read out one beat per cycle while
//  popped, via the single RAM read port, idle between blocks. Full rises while
//  both banks wait. Key order tables settle via the rank and encode registers.
//  Reset clears control state only; the block store needs no clearing pass.
// ----------------------------------------------------------------------------
module keyed_block_transposition (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte,
  input  logic                          in_final,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          out_run_last,
  output logic                          out_message_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  logic [kbt_pkg::LEN_W-1:0] key_length_r;
  logic [kbt_pkg::KEY_W-1:0] key_bytes_r;
  logic                      decode_mode_r;
  logic [kbt_pkg::LEN_W-1:0] len;

  logic                       we;
  logic [kbt_pkg::RAM_AW-1:0] waddr;
  logic [7:0]                 wdata;
  logic                       re;
  logic [kbt_pkg::RAM_AW-1:0] raddr;
  logic                       job_push;
  kbt_pkg::kbt_job_t          job_in;
  kbt_pkg::kbt_job_t          job_out;
  logic                       q_empty;
  logic                       q_pop;
  kbt_pkg::kbt_release_t      rel;
  kbt_pkg::kbt_idx_vec_t      enc_src;
  kbt_pkg::kbt_idx_vec_t      dec_src;

  assign cfg_ready = 1'b1;
  assign len       = kbt_pkg::eff_len(key_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r  <= kbt_pkg::LEN_W'(1);
      key_bytes_r   <= '0;
      decode_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kbt_pkg::CFG_KEY_LENGTH:  key_length_r  <= cfg_data[kbt_pkg::LEN_W-1:0];
        kbt_pkg::CFG_KEY_BYTES:   key_bytes_r   <= cfg_data[kbt_pkg::KEY_W-1:0];
        kbt_pkg::CFG_DECODE_MODE: decode_mode_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  kbt_order u_order (
    .clk       (clk),
    .key_bytes (key_bytes_r),
    .len       (len),
    .enc_src   (enc_src),
    .dec_src   (dec_src)
  );

  kbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_final  (in_final),
    .len       (len),
    .release_i (rel),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .job_push  (job_push),
    .job       (job_in)
  );

  kbt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (job_push),
    .wr_job (job_in),
    .rd     (q_pop),
    .empty  (q_empty),
    .rd_job (job_out)
  );

  kbt_ram #(
    .WIDTH (8),
    .DEPTH (kbt_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (out_byte)
  );

  kbt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (job_out),
    .q_pop           (q_pop),
    .decode_mode     (decode_mode_r),
    .enc_src         (enc_src),
    .dec_src         (dec_src),
    .re              (re),
    .raddr           (raddr),
    .release_o       (rel),
    .pop             (pop),
    .empty           (empty),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

endmodule

// ===== bench/tb_keyed_block_transposition.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_block_transposition
// Self-checking bench for the keyed block transposition. A queue-fed driver
// pushes message bytes with random gaps, and a monitor pops result beats
// with random stalls. Each beat is checked against a predictor that keeps its
// own block buffer and key order. Key length, key bytes and direction are
// changed between phases once the output has drained. The phases include the
// length extremes, ties and zeros in the key, and a key length lowered
// while a block is still open.
// ----------------------------------------------------------------------------
module tb_keyed_block_transposition;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } msg_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       msg_end;
  } out_beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic [7:0]                    in_byte = 8'h00;
  logic                          in_final = 1'b0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [7:0]                    out_byte;
  logic                          out_run_last;
  logic                          out_message_end;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [kbt_pkg::CFG_IDX_W-1:0] cfg_index = kbt_pkg::CFG_KEY_LENGTH;
  logic [63:0]                   cfg_data = 64'd0;

  msg_beat_t   msg_queue[$];
  out_beat_t   expected_beats[$];
  msg_beat_t   next_beat;
  out_beat_t   want;
  bit          tx_busy = 1'b0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned errors = 0;

  logic [3:0]  key_len_reg = 4'd1;
  logic [63:0] key_reg = 64'd0;
  logic        decode_reg = 1'b0;
  logic [7:0]  held_bytes[kbt_pkg::KEY_MAX];
  int unsigned held_count = 0;

  keyed_block_transposition DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_final        (in_final),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_len(input bit en);
    int unsigned r;
    if (!en) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Buffers one accepted byte and queues the beats it releases.
  function automatic void transpose_byte(input logic [7:0] b, input logic fin);
    int unsigned blen, n, i, j, c;
    int unsigned rank[kbt_pkg::KEY_MAX];
    logic [7:0]  res[kbt_pkg::KEY_MAX];
    out_beat_t   ob;
    blen = 32'(key_len_reg);
    if (blen == 0) blen = 1;
    if (blen > kbt_pkg::KEY_MAX) blen = kbt_pkg::KEY_MAX;
    n = 0;
    if (held_count >= blen) held_count = 0;
    held_bytes[held_count] = b;
    held_count++;
    if (held_count == blen) begin
      for (i = 0; i < blen; i++) rank[i] = i;
      for (i = 1; i < blen; i++) begin
        c = rank[i];
        j = i;
        while (j > 0 && key_reg[8*rank[j-1] +: 8] > key_reg[8*c +: 8]) begin
          rank[j] = rank[j-1];
          j--;
        end
        rank[j] = c;
      end
      for (i = 0; i < blen; i++) begin
        if (!decode_reg) res[i] = held_bytes[rank[i]];
        else res[rank[i]] = held_bytes[i];
      end
      n = blen;
      held_count = 0;
    end else if (fin) begin
      for (i = 0; i < held_count; i++) res[i] = held_bytes[i];
      n = held_count;
      held_count = 0;
    end
    for (i = 0; i < n; i++) begin
      ob.data = res[i];
      ob.run_last = (i + 1 == n);
      ob.msg_end = (i + 1 == n) && fin;
      expected_beats.push_back(ob);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      tx_wait = 0;
    end else begin
      if (push && !full) begin
        transpose_byte(in_byte, in_final);
        tx_busy = 1'b0;
        tx_wait = idle_len(tx_idle_en);
      end
      if (!push || !full) begin
        if (tx_wait > 0) begin
          tx_wait--;
          push <= 1'b0;
        end else if (msg_queue.size() != 0) begin
          next_beat = msg_queue.pop_front();
          tx_busy = 1'b1;
          push <= 1'b1;
          in_byte <= next_beat.data;
          in_final <= next_beat.fin;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got byte %02h run_last %b end %b",
                   $time, out_byte, out_run_last, out_message_end);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte);
            errors++;
          end
          if (out_run_last !== want.run_last) begin
            $display("%0t: out_run_last expected %b, got %b",
                     $time, want.run_last, out_run_last);
            errors++;
          end
          if (out_message_end !== want.msg_end) begin
            $display("%0t: out_message_end expected %b, got %b",
                     $time, want.msg_end, out_message_end);
            errors++;
          end
        end
        rx_wait = idle_len(rx_idle_en);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      pop <= (rx_wait == 0);
    end
  end

  task automatic add_beat(input logic [7:0] data, input logic fin);
    msg_beat_t mb;
    mb.data = data;
    mb.fin = fin;
    msg_queue.push_back(mb);
  endtask

  // A run is a closed message, an open partial message, or noise with
  // random final flags.
  task automatic add_run(input int unsigned n, input bit closed, input bit noisy);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      add_beat(8'($urandom_range(255)),
               noisy ? ($urandom_range(3) == 0) : (closed && i == n - 1));
    end
  endtask

  task automatic drain();
    while (msg_queue.size() != 0 || tx_busy || expected_beats.size() != 0)
      @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_reg(input kbt_pkg::kbt_cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      kbt_pkg::CFG_KEY_LENGTH:  key_len_reg = val[3:0];
      kbt_pkg::CFG_KEY_BYTES:   key_reg = val;
      kbt_pkg::CFG_DECODE_MODE: decode_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [3:0] len, input logic [63:0] key,
                            input logic dec);
    write_reg(kbt_pkg::CFG_KEY_LENGTH, {60'd0, len});
    write_reg(kbt_pkg::CFG_KEY_BYTES, key);
    write_reg(kbt_pkg::CFG_DECODE_MODE, {63'd0, dec});
    cfg_valid <= 1'b0;
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned sent, chunk, phase, half, n, i;
    logic [3:0]  len;
    logic [63:0] key;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: block length one, encode.
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b1);
    drain();

    // Tied key bytes; the final byte completes a block, then a short tail.
    set_config(4'd4, 64'h0000_0000_1020_1030, 1'b0);
    add_beat(8'h11, 1'b0);
    add_beat(8'h22, 1'b0);
    add_beat(8'h33, 1'b0);
    add_beat(8'h44, 1'b1);
    add_beat(8'h55, 1'b0);
    add_beat(8'h66, 1'b1);
    drain();

    set_config(4'd4, 64'h0000_0000_1020_1030, 1'b1);
    add_beat(8'hAA, 1'b0);
    add_beat(8'hBB, 1'b0);
    add_beat(8'hCC, 1'b0);
    add_beat(8'hDD, 1'b0);
    drain();

    // A zero length acts as one.
    set_config(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_beat(8'h5A, 1'b0);
    drain();

    // Length above the maximum saturates; leave five bytes open.
    set_config(4'd15, 64'h0011_2233_4455_6677, 1'b1);
    add_run(5, 1'b0, 1'b0);
    drain();

    // Shorter length with the block still open drops the stale bytes.
    set_config(4'd3, 64'hFF00_0000_0000_0000, 1'b0);
    add_run(3, 1'b0, 1'b0);
    drain();

    sent = 0;
    phase = 0;
    while (sent < 350) begin
      n = $urandom_range(9);
      if (n == 0) len = $urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15));
      else len = 4'($urandom_range(1, 8));
      case ($urandom_range(4))
        0: key = 64'd0;
        1: key = 64'hFFFF_FFFF_FFFF_FFFF;
        2: for (i = 0; i < 8; i++) key[8*i +: 8] = 8'($urandom_range(3));
        default: key = {$urandom, $urandom};
      endcase
      set_config(len, key, 1'($urandom_range(1)));
      tx_idle_en = ($urandom_range(3) != 0);
      rx_idle_en = ($urandom_range(3) != 0);
      for (half = 0; half < 2; half++) begin
        chunk = 0;
        while (chunk < 17) begin
          if ($urandom_range(9) < 8) begin
            n = $urandom_range(1, 20);
            add_run(n, 1'b1, 1'b0);
          end else begin
            n = $urandom_range(1, 4);
            add_run(n, 1'b0, 1'b1);
          end
          chunk += n;
        end
        sent += chunk;
        // Hold the sender until every beat so far has come out.
        if (half == 0 && phase % 3 == 1) drain();
      end
      if ($urandom_range(1)) begin
        n = $urandom_range(1, 7);
        add_run(n, 1'b0, 1'b0);
        sent += n;
      end
      drain();
      phase++;
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
